/* sv/gmce_pkg.sv */
// ----------------------------------------------------------------------------
// gmce_pkg
// Shared types and constants for the grid maze carve engine.
// ----------------------------------------------------------------------------
`default_nettype none

package gmce_pkg;

   // default grid side used to size the passage store
   localparam int GRID_SIDE_MAX_DEF = 64;
   // coordinates are 6 bits wide, so the grid never exceeds this side
   localparam int SIDE_CAP          = 64;
   localparam int NEIGHBOR_SLOTS    = 4;

   localparam int COORD_W = 6;
   localparam int ACT_W   = 2;
   localparam int IDX_W   = 31;
   localparam int CFG_W   = 7;
   localparam int PER_W   = 8;
   localparam int PASS_W  = 4;
   localparam int REQ_W   = 56;
   localparam int RSP_W   = 16;
   localparam int CSR_AW  = 1;
   localparam int SLOT_W  = 2;

   localparam logic [CFG_W-1:0] SIDE_RESET = 7'd16;
   localparam logic [CFG_W-1:0] SIDE_MIN   = 7'd2;

   // action codes
   localparam logic [ACT_W-1:0] ACT_QUERY = 2'd0;
   localparam logic [ACT_W-1:0] ACT_LINK  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_PERIM = 2'd2;

   // register indexes
   localparam logic [CSR_AW-1:0] CSR_GRID_WIDTH  = 1'b0;
   localparam logic [CSR_AW-1:0] CSR_GRID_HEIGHT = 1'b1;

   // passage bits
   localparam logic [PASS_W-1:0] PASS_NONE  = 4'b0000;
   localparam logic [PASS_W-1:0] PASS_UP    = 4'b0001;
   localparam logic [PASS_W-1:0] PASS_RIGHT = 4'b0010;
   localparam logic [PASS_W-1:0] PASS_DOWN  = 4'b0100;
   localparam logic [PASS_W-1:0] PASS_LEFT  = 4'b1000;

   // neighbor slots in report order
   localparam logic [SLOT_W-1:0] SLOT_UP    = 2'd0;
   localparam logic [SLOT_W-1:0] SLOT_RIGHT = 2'd1;
   localparam logic [SLOT_W-1:0] SLOT_DOWN  = 2'd2;
   localparam logic [SLOT_W-1:0] SLOT_LEFT  = 2'd3;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_Q_READ,
      ST_Q_LATCH,
      ST_Q_EMIT,
      ST_L_RD_HEAD,
      ST_L_RD_OTHER,
      ST_L_WR_OTHER,
      ST_P_WAIT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic             done;
      logic [PER_W-1:0] rem;
   } mod_stat_type;

endpackage

`default_nettype wire

/* sv/grid_maze_carve_engine.sv */
// ----------------------------------------------------------------------------
// grid_maze_carve_engine
// Passage store for a tile grid with neighbor query, tile linking and
// border lookup, run by a small sequencer around one RAM port
// pair and a bit-serial remainder unit.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------
//  req     | in        | req_tvalid/tready    | req_tdata, req_tuser
//  rsp     | out       | rsp_tvalid/tready    | rsp_tdata, rsp_tuser, rsp_tlast
//  csr     | in        | csr_we               | csr_addr, csr_wdata
//
// After reset the passage store is swept to zero, one tile per cycle
// (GRID_SIDE_MAX*GRID_SIDE_MAX tiles, 4096 by default); req_tready is low
// until the sweep ends. A query does four RAM reads, each with a registered
// read, then emits its results; a link reads and writes both tiles; a border
// lookup waits on the 31 steps of the remainder unit.
// One item is worked at a time; the result register lets the next item in
// while the final result of the previous one still waits on rsp_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_maze_carve_engine #(
   parameter int GRID_SIDE_MAX = gmce_pkg::GRID_SIDE_MAX_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   // tile_col[5:0], tile_row[11:6], other_col[17:12], other_row[23:18],
   // perimeter_index[54:24], zero fill above
   input  wire logic [gmce_pkg::REQ_W-1:0]   req_tdata,
   // action[1:0]
   input  wire logic [gmce_pkg::ACT_W-1:0]   req_tuser,
   // result_col[5:0], result_row[11:6], zero fill above
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic      [gmce_pkg::RSP_W-1:0]   rsp_tdata,
   // found[0]
   output logic                              rsp_tuser,
   output logic                              rsp_tlast,
   input  wire logic                         csr_we,
   input  wire logic [gmce_pkg::CSR_AW-1:0]  csr_addr,
   input  wire logic [gmce_pkg::CFG_W-1:0]   csr_wdata
);

   localparam int DEPTH   = GRID_SIDE_MAX * GRID_SIDE_MAX;
   localparam int AW      = $clog2(DEPTH);
   localparam int SIDE_LIMIT = (GRID_SIDE_MAX < gmce_pkg::SIDE_CAP) ?
                               GRID_SIDE_MAX : gmce_pkg::SIDE_CAP;
   localparam int COORD_W = gmce_pkg::COORD_W;
   localparam int CFG_W   = gmce_pkg::CFG_W;
   localparam int PER_W   = gmce_pkg::PER_W;
   localparam int PASS_W  = gmce_pkg::PASS_W;
   localparam int SLOTS   = gmce_pkg::NEIGHBOR_SLOTS;
   localparam int SLOT_W  = gmce_pkg::SLOT_W;
   localparam logic [CFG_W-1:0] SIDE_HI = CFG_W'(SIDE_LIMIT);
   localparam logic [AW-1:0]    CLR_LAST = AW'(DEPTH - 1);

   function automatic logic [AW-1:0] tile_addr(input logic [COORD_W-1:0] col,
                                                input logic [COORD_W-1:0] row);
      tile_addr = AW'(int'(row) * GRID_SIDE_MAX + int'(col));
   endfunction

   gmce_pkg::state_type state_ff, state_in;

   // configuration
   logic [CFG_W-1:0] gw_ff, gw_in;
   logic [CFG_W-1:0] gh_ff, gh_in;

   // latched item
   logic [gmce_pkg::ACT_W-1:0] act_ff, act_in;
   logic [COORD_W-1:0] col_ff, col_in;
   logic [COORD_W-1:0] row_ff, row_in;
   logic [COORD_W-1:0] ocol_ff, ocol_in;
   logic [COORD_W-1:0] orow_ff, orow_in;
   logic [gmce_pkg::IDX_W-1:0] pidx_ff, pidx_in;

   // sequencer data
   logic [AW-1:0]     clr_ff, clr_in;
   logic [SLOT_W-1:0] k_ff, k_in;
   logic [SLOTS-1:0]  free_ff, free_in;
   logic [COORD_W-1:0] res_col_ff, res_col_in;
   logic [COORD_W-1:0] res_row_ff, res_row_in;
   logic               res_found_ff, res_found_in;

   // result register
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic [COORD_W-1:0] rsp_col_ff, rsp_col_in;
   logic [COORD_W-1:0] rsp_row_ff, rsp_row_in;
   logic               rsp_found_ff, rsp_found_in;
   logic               rsp_last_ff, rsp_last_in;

   // controls from the output decode
   logic               ram_wr_en;
   logic [AW-1:0]      ram_wr_addr;
   logic [PASS_W-1:0]  ram_wr_data;
   logic               ram_rd_en;
   logic [AW-1:0]      ram_rd_addr;
   logic [PASS_W-1:0]  ram_rd_data;
   logic               mod_start;
   logic               out_load;
   logic [COORD_W-1:0] out_col;
   logic [COORD_W-1:0] out_row;
   logic               out_found;
   logic               out_last;
   logic               res_load;
   logic [COORD_W-1:0] res_col;
   logic [COORD_W-1:0] res_row;
   logic               res_found;

   gmce_pkg::mod_stat_type mod_stat;

   // clamped grid size and derived values
   logic [CFG_W-1:0]   w_eff, h_eff;
   logic [COORD_W-1:0] wd, hd;
   logic [PER_W-1:0]   per_len;
   logic [PER_W-1:0]   wd8, hd8, edge1, edge2;
   logic [COORD_W-1:0] per_col, per_row;

   logic               slot_free;
   logic               head_ok, other_ok, link_ok;
   logic [PASS_W-1:0]  head_bit, other_bit;

   logic [COORD_W-1:0] nb_col [SLOTS];
   logic [COORD_W-1:0] nb_row [SLOTS];
   logic [SLOTS-1:0]   nb_ok;
   logic [SLOT_W-1:0]  q_sel;
   logic [SLOTS-1:0]   q_rest;
   logic               q_done;

   assign w_eff = (gw_ff < gmce_pkg::SIDE_MIN) ? gmce_pkg::SIDE_MIN :
                  (gw_ff > SIDE_HI) ? SIDE_HI : gw_ff;
   assign h_eff = (gh_ff < gmce_pkg::SIDE_MIN) ? gmce_pkg::SIDE_MIN :
                  (gh_ff > SIDE_HI) ? SIDE_HI : gh_ff;
   assign wd = COORD_W'(w_eff - 7'd1);
   assign hd = COORD_W'(h_eff - 7'd1);
   assign wd8 = PER_W'(wd);
   assign hd8 = PER_W'(hd);
   assign per_len = {wd8[PER_W-2:0], 1'b0} + {hd8[PER_W-2:0], 1'b0};
   assign edge1 = wd8 + hd8;
   assign edge2 = edge1 + wd8;

   // border walk from top-left: top, right, bottom (rightward), left (downward)
   always_comb begin
      if (mod_stat.rem < wd8) begin
         per_col = COORD_W'(mod_stat.rem);
         per_row = '0;
      end else if (mod_stat.rem < edge1) begin
         per_col = wd;
         per_row = COORD_W'(mod_stat.rem - wd8);
      end else if (mod_stat.rem < edge2) begin
         per_col = COORD_W'(mod_stat.rem - edge1);
         per_row = hd;
      end else begin
         per_col = '0;
         per_row = COORD_W'(mod_stat.rem - edge2);
      end
   end

   assign slot_free = !rsp_tvalid_ff || rsp_tready;

   assign head_ok  = ({1'b0, col_ff} < w_eff) && ({1'b0, row_ff} < h_eff);
   assign other_ok = ({1'b0, ocol_ff} < w_eff) && ({1'b0, orow_ff} < h_eff);

   always_comb begin
      head_bit  = gmce_pkg::PASS_NONE;
      other_bit = gmce_pkg::PASS_NONE;
      if (col_ff == ocol_ff && orow_ff < row_ff) begin
         head_bit  = gmce_pkg::PASS_UP;
         other_bit = gmce_pkg::PASS_DOWN;
      end else if (col_ff == ocol_ff && row_ff < orow_ff) begin
         head_bit  = gmce_pkg::PASS_DOWN;
         other_bit = gmce_pkg::PASS_UP;
      end else if (row_ff == orow_ff && ocol_ff < col_ff) begin
         head_bit  = gmce_pkg::PASS_LEFT;
         other_bit = gmce_pkg::PASS_RIGHT;
      end else if (row_ff == orow_ff && col_ff < ocol_ff) begin
         head_bit  = gmce_pkg::PASS_RIGHT;
         other_bit = gmce_pkg::PASS_LEFT;
      end
   end

   assign link_ok = head_ok && other_ok && (head_bit != gmce_pkg::PASS_NONE);

   // neighbor candidates in report order
   always_comb begin
      nb_col[gmce_pkg::SLOT_UP]    = col_ff;
      nb_row[gmce_pkg::SLOT_UP]    = row_ff - 1'b1;
      nb_ok[gmce_pkg::SLOT_UP]     = row_ff != '0;
      nb_col[gmce_pkg::SLOT_RIGHT] = col_ff + 1'b1;
      nb_row[gmce_pkg::SLOT_RIGHT] = row_ff;
      nb_ok[gmce_pkg::SLOT_RIGHT]  = (CFG_W'(col_ff) + 7'd1) < w_eff;
      nb_col[gmce_pkg::SLOT_DOWN]  = col_ff;
      nb_row[gmce_pkg::SLOT_DOWN]  = row_ff + 1'b1;
      nb_ok[gmce_pkg::SLOT_DOWN]   = (CFG_W'(row_ff) + 7'd1) < h_eff;
      nb_col[gmce_pkg::SLOT_LEFT]  = col_ff - 1'b1;
      nb_row[gmce_pkg::SLOT_LEFT]  = row_ff;
      nb_ok[gmce_pkg::SLOT_LEFT]   = col_ff != '0;
   end

   // lowest free slot still to report
   always_comb begin
      if (free_ff[gmce_pkg::SLOT_UP]) begin
         q_sel = gmce_pkg::SLOT_UP;
      end else if (free_ff[gmce_pkg::SLOT_RIGHT]) begin
         q_sel = gmce_pkg::SLOT_RIGHT;
      end else if (free_ff[gmce_pkg::SLOT_DOWN]) begin
         q_sel = gmce_pkg::SLOT_DOWN;
      end else begin
         q_sel = gmce_pkg::SLOT_LEFT;
      end
      q_rest = free_ff & ~(SLOTS'(1) << q_sel);
      q_done = (free_ff == '0) || (q_rest == '0);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gmce_pkg::ST_CLEAR: begin
            if (clr_ff == CLR_LAST) state_in = gmce_pkg::ST_IDLE;
         end
         gmce_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = gmce_pkg::ST_DISPATCH;
         end
         gmce_pkg::ST_DISPATCH: begin
            case (act_ff)
               gmce_pkg::ACT_QUERY: begin
                  state_in = head_ok ? gmce_pkg::ST_Q_READ : gmce_pkg::ST_EMIT;
               end
               gmce_pkg::ACT_LINK: begin
                  state_in = link_ok ? gmce_pkg::ST_L_RD_HEAD : gmce_pkg::ST_EMIT;
               end
               gmce_pkg::ACT_PERIM: state_in = gmce_pkg::ST_P_WAIT;
               default:             state_in = gmce_pkg::ST_EMIT;
            endcase
         end
         gmce_pkg::ST_Q_READ:  state_in = gmce_pkg::ST_Q_LATCH;
         gmce_pkg::ST_Q_LATCH: begin
            state_in = (k_ff == gmce_pkg::SLOT_LEFT) ? gmce_pkg::ST_Q_EMIT :
                                                       gmce_pkg::ST_Q_READ;
         end
         gmce_pkg::ST_Q_EMIT: begin
            if (slot_free && q_done) state_in = gmce_pkg::ST_IDLE;
         end
         gmce_pkg::ST_L_RD_HEAD:  state_in = gmce_pkg::ST_L_RD_OTHER;
         gmce_pkg::ST_L_RD_OTHER: state_in = gmce_pkg::ST_L_WR_OTHER;
         gmce_pkg::ST_L_WR_OTHER: state_in = gmce_pkg::ST_EMIT;
         gmce_pkg::ST_P_WAIT: begin
            if (mod_stat.done) state_in = gmce_pkg::ST_EMIT;
         end
         gmce_pkg::ST_EMIT: begin
            if (slot_free) state_in = gmce_pkg::ST_IDLE;
         end
         default: state_in = gmce_pkg::ST_IDLE;
      endcase
   end

   // output decode
   always_comb begin
      req_tready  = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = tile_addr(ocol_ff, orow_ff);
      ram_wr_data = ram_rd_data | other_bit;
      ram_rd_en   = 1'b0;
      ram_rd_addr = tile_addr(nb_col[k_ff], nb_row[k_ff]);
      mod_start   = 1'b0;
      out_load    = 1'b0;
      out_col     = res_col_ff;
      out_row     = res_row_ff;
      out_found   = res_found_ff;
      out_last    = 1'b1;
      res_load    = 1'b0;
      res_col     = '0;
      res_row     = '0;
      res_found   = 1'b0;
      case (state_ff)
         gmce_pkg::ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = gmce_pkg::PASS_NONE;
         end
         gmce_pkg::ST_IDLE: begin
            req_tready = 1'b1;
         end
         gmce_pkg::ST_DISPATCH: begin
            // default reply is an empty result; later states overwrite it
            res_load  = 1'b1;
            mod_start = act_ff == gmce_pkg::ACT_PERIM;
         end
         gmce_pkg::ST_Q_READ: begin
            ram_rd_en = 1'b1;
         end
         gmce_pkg::ST_Q_EMIT: begin
            out_load  = slot_free;
            out_col   = (free_ff == '0) ? '0 : nb_col[q_sel];
            out_row   = (free_ff == '0) ? '0 : nb_row[q_sel];
            out_found = free_ff != '0;
            out_last  = q_done;
         end
         gmce_pkg::ST_L_RD_HEAD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = tile_addr(col_ff, row_ff);
         end
         gmce_pkg::ST_L_RD_OTHER: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = tile_addr(col_ff, row_ff);
            ram_wr_data = ram_rd_data | head_bit;
            ram_rd_en   = 1'b1;
            ram_rd_addr = tile_addr(ocol_ff, orow_ff);
         end
         gmce_pkg::ST_L_WR_OTHER: begin
            ram_wr_en = 1'b1;
            res_load  = 1'b1;
            res_found = 1'b1;
         end
         gmce_pkg::ST_P_WAIT: begin
            res_load  = mod_stat.done;
            res_col   = per_col;
            res_row   = per_row;
            res_found = 1'b1;
         end
         gmce_pkg::ST_EMIT: begin
            out_load = slot_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // register next values
   always_comb begin
      gw_in = gw_ff;
      gh_in = gh_ff;
      if (csr_we) begin
         case (csr_addr)
            gmce_pkg::CSR_GRID_WIDTH:  gw_in = csr_wdata;
            gmce_pkg::CSR_GRID_HEIGHT: gh_in = csr_wdata;
            default:                   gw_in = gw_ff;
         endcase
      end

      act_in  = act_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      ocol_in = ocol_ff;
      orow_in = orow_ff;
      pidx_in = pidx_ff;
      if (req_tvalid && req_tready) begin
         act_in  = req_tuser;
         col_in  = req_tdata[5:0];
         row_in  = req_tdata[11:6];
         ocol_in = req_tdata[17:12];
         orow_in = req_tdata[23:18];
         pidx_in = req_tdata[54:24];
      end

      clr_in = (state_ff == gmce_pkg::ST_CLEAR) ? clr_ff + 1'b1 : clr_ff;

      k_in    = k_ff;
      free_in = free_ff;
      if (state_ff == gmce_pkg::ST_DISPATCH) begin
         k_in    = '0;
         free_in = '0;
      end else if (state_ff == gmce_pkg::ST_Q_LATCH) begin
         k_in          = k_ff + 1'b1;
         free_in[k_ff] = nb_ok[k_ff] && (ram_rd_data == gmce_pkg::PASS_NONE);
      end else if (state_ff == gmce_pkg::ST_Q_EMIT && out_load) begin
         free_in = q_rest;
      end

      res_col_in   = res_load ? res_col   : res_col_ff;
      res_row_in   = res_load ? res_row   : res_row_ff;
      res_found_in = res_load ? res_found : res_found_ff;

      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_col_in    = rsp_col_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_last_in   = rsp_last_ff;
      if (out_load) begin
         rsp_tvalid_in = 1'b1;
         rsp_col_in    = out_col;
         rsp_row_in    = out_row;
         rsp_found_in  = out_found;
         rsp_last_in   = out_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= gmce_pkg::ST_CLEAR;
         gw_ff         <= gmce_pkg::SIDE_RESET;
         gh_ff         <= gmce_pkg::SIDE_RESET;
         clr_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         gw_ff         <= gw_in;
         gh_ff         <= gh_in;
         clr_ff        <= clr_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      act_ff       <= act_in;
      col_ff       <= col_in;
      row_ff       <= row_in;
      ocol_ff      <= ocol_in;
      orow_ff      <= orow_in;
      pidx_ff      <= pidx_in;
      k_ff         <= k_in;
      free_ff      <= free_in;
      res_col_ff   <= res_col_in;
      res_row_ff   <= res_row_in;
      res_found_ff <= res_found_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_found_ff <= rsp_found_in;
      rsp_last_ff  <= rsp_last_in;
   end

   gmce_ram #(
      .WIDTH (PASS_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   gmce_mod u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (pidx_ff),
      .divisor  (per_len),
      .stat     (mod_stat)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(gmce_pkg::RSP_W - 2 * COORD_W){1'b0}}, rsp_row_ff, rsp_col_ff};
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_clear_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gmce_pkg::ST_CLEAR) |-> !req_tready)
      else $error("item taken during store sweep");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_tvalid_ff || rsp_tready))
      else $error("pending result overwritten");

   a_query_read_only: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gmce_pkg::ST_Q_READ || state_ff == gmce_pkg::ST_Q_LATCH)
      |-> !ram_wr_en)
      else $error("store written during a neighbor query");

   a_mod_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      mod_stat.done |-> (state_ff == gmce_pkg::ST_P_WAIT))
      else $error("remainder finished outside border lookup");

endmodule

`default_nettype wire

/* sv/gmce_ram.sv */
// ----------------------------------------------------------------------------
// gmce_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gmce_ram #(
   parameter int WIDTH = gmce_pkg::PASS_W,
   parameter int DEPTH = gmce_pkg::GRID_SIDE_MAX_DEF * gmce_pkg::GRID_SIDE_MAX_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* sv/gmce_mod.sv */
// ----------------------------------------------------------------------------
// gmce_mod
// Restoring remainder unit: one dividend bit per cycle through a shared
// subtract and compare.
// ----------------------------------------------------------------------------
`default_nettype none

module gmce_mod (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [gmce_pkg::IDX_W-1:0]  dividend,
   input  wire logic [gmce_pkg::PER_W-1:0]  divisor,
   output gmce_pkg::mod_stat_type           stat
);

   localparam int IDX_W = gmce_pkg::IDX_W;
   localparam int PER_W = gmce_pkg::PER_W;
   localparam int CNT_W = $clog2(IDX_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0] num_ff, num_in;
   logic [PER_W-1:0] div_ff, div_in;
   logic [PER_W-1:0] rem_ff, rem_in;

   logic [PER_W:0] trial;
   logic [PER_W:0] diff;
   logic           fits;

   assign trial = {rem_ff, num_ff[IDX_W-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         // partial remainder stays below the divisor, so it fits PER_W bits
         rem_in = fits ? diff[PER_W-1:0] : trial[PER_W-1:0];
         num_in = {num_ff[IDX_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(IDX_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign stat.done = done_ff;
   assign stat.rem  = rem_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("remainder unit restarted while busy");

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < div_ff))
      else $error("remainder not reduced below divisor");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(done_ff) |-> $fell(busy_ff))
      else $error("done raised without finishing the bit loop");

endmodule

`default_nettype wire
